// ===== rtl/ssba_pkg.sv =====
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types, constants and helpers for the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

  // slot map geometry
  localparam int SLOTS            = 1024;
  localparam int SECTORS_PER_SLOT = 8;
  localparam int WORD_W           = 32;
  localparam int WORDS            = SLOTS / WORD_W;
  localparam int WADDR_W          = $clog2(WORDS);
  localparam int BIT_W            = $clog2(WORD_W);

  // field widths
  localparam int ACT_W    = 2;
  localparam int SLOT_W   = 10;
  localparam int CNT_W    = 11;
  localparam int SECTOR_W = 13;
  localparam int STAT_W   = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd3;

  // request word
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot_index;
  } request_t;

  // result word
  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [SECTOR_W-1:0] first_sector;
    logic                in_use;
    logic [CNT_W-1:0]    free_slots;
    logic [STAT_W-1:0]   status;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic fetch;
    logic commit;
    logic fail;
    logic check;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic hit;
    logic last;
  } dp_stat_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_CHECK,
    S_DONE
  } ctrl_state_t;

  // lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // first sector of a slot, kept to the field width
  function automatic logic [SECTOR_W-1:0] sector_of(input logic [SLOT_W-1:0] s);
    logic [31:0] p;
    p = 32'(s) * 32'(SECTORS_PER_SLOT);
    return p[SECTOR_W-1:0];
  endfunction

endpackage

// ===== rtl/ssba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssba_ctrl
// Sequencer for the allocator: accepts a request, steps the bitmap scan
// or the single-word check, and strobes the result.
// ----------------------------------------------------------------------------
module ssba_ctrl import ssba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = stat.is_alloc ? S_SCAN : S_CHECK;
      end
      S_SCAN: begin
        if (stat.hit || stat.last) state_next = S_DONE;
      end
      S_CHECK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.commit = 1'b1;
        end else if (stat.last) begin
          cmd.fail = 1'b1;
        end else begin
          cmd.fetch = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // result strobe lasts one cycle and frees the block
  assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("result strobe not followed by idle");

  // an accepted request makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // at most one datapath action per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.fetch, cmd.commit, cmd.fail, cmd.check}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/ssba_dp.sv =====
// ----------------------------------------------------------------------------
// ssba_dp
// Datapath: word-organised used map in a RAM with per-row valid bits,
// free-slot counter, slot-count register and result register.
// ----------------------------------------------------------------------------
module ssba_dp import ssba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  input  request_t         request,
  output dp_stat_t         stat,
  output result_t          result
);

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORDS-1:0]   row_valid;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   free_count, free_count_next;
  logic [ACT_W-1:0]   act;
  logic [SLOT_W-1:0]  idx;
  logic [WADDR_W-1:0] ptr;
  logic [WADDR_W-1:0] rd_word;
  logic [WORD_W-1:0]  rdata;
  logic               rvalid;
  result_t            res;

  logic [WORD_W-1:0]  word_eff;
  logic [WORD_W-1:0]  in_range;
  logic [WORD_W-1:0]  avail;
  logic [BIT_W-1:0]   hit_bit;
  logic [BIT_W-1:0]   sel_bit;
  logic               cur_used;
  logic               oor;
  logic               mem_we;
  logic [WORD_W-1:0]  mem_wdata;
  logic [CNT_W-1:0]   cfg_sat;
  logic [CNT_W-1:0]   word_base;
  logic [SLOT_W-1:0]  hit_slot;

  // slot count saturates at the map size
  assign cfg_sat = (cfg_data > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_data;

  // rows never written since the last clear read as all free
  assign word_eff  = rvalid ? rdata : '0;
  assign word_base = {1'b0, rd_word, {BIT_W{1'b0}}};

  // bits of the fetched word that lie below the slot count
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      in_range[b] = (word_base + CNT_W'(b)) < lim;
    end
  end

  assign avail    = ~word_eff & in_range;
  assign hit_bit  = lowest_set(avail);
  assign hit_slot = {rd_word, hit_bit};
  assign sel_bit  = idx[BIT_W-1:0];
  assign cur_used = word_eff[sel_bit];
  assign oor      = {1'b0, idx} >= lim;

  // status to the controller
  assign stat.is_alloc = (act == ACT_ALLOC);
  assign stat.hit      = |avail;
  assign stat.last     = (word_base + CNT_W'(WORD_W)) >= lim;

  // map write and counter update
  always_comb begin
    mem_we          = 1'b0;
    mem_wdata       = word_eff;
    free_count_next = free_count;
    if (cmd.commit) begin
      mem_we                = 1'b1;
      mem_wdata[hit_bit]    = 1'b1;
      if (free_count != '0) free_count_next = free_count - 1'b1;
    end else if (cmd.check && (act == ACT_FREE) && !oor && cur_used) begin
      mem_we                = 1'b1;
      mem_wdata[sel_bit]    = 1'b0;
      if (free_count < lim) free_count_next = free_count + 1'b1;
    end
  end

  // bitmap ram, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[rd_word] <= mem_wdata;
    if (cmd.fetch) rdata <= mem[ptr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim        <= CNT_W'(SLOTS);
      free_count <= CNT_W'(SLOTS);
      row_valid  <= '0;
      rvalid     <= 1'b0;
    end else if (cfg_we) begin
      lim        <= cfg_sat;
      free_count <= cfg_sat;
      row_valid  <= '0;
      rvalid     <= 1'b0;
    end else begin
      free_count <= free_count_next;
      if (mem_we) row_valid[rd_word] <= 1'b1;
      if (cmd.fetch) rvalid <= row_valid[ptr];
    end
  end

  // request capture and word pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= request.action;
      idx <= request.slot_index;
      ptr <= (request.action == ACT_ALLOC) ? '0 : request.slot_index[SLOT_W-1 -: WADDR_W];
    end else if (cmd.fetch) begin
      rd_word <= ptr;
      ptr     <= ptr + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    priority if (cmd.commit) begin
      res.slot_out     <= hit_slot;
      res.first_sector <= sector_of(hit_slot);
      res.in_use       <= 1'b1;
      res.free_slots   <= free_count_next;
      res.status       <= ST_OK;
    end else if (cmd.fail) begin
      res.slot_out     <= '0;
      res.first_sector <= '0;
      res.in_use       <= 1'b0;
      res.free_slots   <= free_count;
      res.status       <= ST_FULL;
    end else if (cmd.check) begin
      res.slot_out     <= idx;
      res.first_sector <= sector_of(idx);
      res.free_slots   <= free_count_next;
      priority if (oor) begin
        res.in_use <= 1'b0;
        res.status <= ST_RANGE;
      end else if (act == ACT_FREE) begin
        res.in_use <= 1'b0;
        res.status <= cur_used ? ST_OK : ST_NOTUSED;
      end else begin
        res.in_use <= cur_used;
        res.status <= ST_OK;
      end
    end
  end

  assign result = res;

  // the free count never exceeds the slot count
  assert property (@(posedge clk) disable iff (rst) free_count <= lim)
    else $error("free count above slot count");

  // a slot-count write empties the map
  assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (free_count == lim) && (row_valid == '0))
    else $error("map not cleared by slot-count write");

endmodule

// ===== rtl/swap_slot_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// First-fit allocator over a used bit per swap slot, with free count.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; its result
// word appears for exactly one cycle with done high and cannot be held off.
// Free and test read the addressed word and then check it. Allocate scans
// the used map one 32-bit word per cycle through the single read port of
// the bitmap RAM until it finds a free slot or reaches the last word below
// the slot count. A slot-count write (cfg_valid with cfg_ready) is taken only
// while busy is low and clears the map at once through per-word valid bits,
// so no clearing pass follows reset or a write.
module swap_slot_bitmap_allocator import ssba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  request_t         request,
  output logic             busy,
  output logic             done,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  // configuration only while idle
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer
  ssba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // map, counters and result
  ssba_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .request  (request),
    .stat     (stat),
    .result   (result)
  );

endmodule
